// File: rtl/base64_stream_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared assertion helpers for the encoder modules. Each one is clocked on
// clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define B64SE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define B64SE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define B64SE_ASSERT(lbl, prop, msg)
`define B64SE_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/b64se_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Payload types, the group record passed between the front and back ends,
// and the Base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64se_pkg;

   // Input transfer: one message byte and its end-of-message mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_payload_type;

   // Output transfer: one ASCII character and its end-of-message mark.
   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } rsp_payload_type;

   // A closed group of up to three bytes, zero-filled, ready to encode.
   // held_count is the number of bytes held before the closing byte (0..2).
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] held_count;
      logic       last;
   } group_type;

   localparam int unsigned QueueDepth = 2;
   localparam logic [7:0]  PadChar    = 8'h3D;

   // Map a 6-bit index onto the standard Base64 alphabet.
   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] wide;
      logic [7:0] code;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         code = wide + 8'h41;
      end else if (idx < 6'd52) begin
         code = wide + 8'h47;
      end else if (idx < 6'd62) begin
         code = wide - 8'd4;
      end else if (idx == 6'd62) begin
         code = 8'h2B;
      end else begin
         code = 8'h2F;
      end
      return code;
   endfunction

endpackage

// File: rtl/base64_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder unit
// Encodes a byte stream into standard Base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// The unit takes one message byte per transfer on the req_ channel and gives
// one ASCII character per transfer on the rsp_ channel. Every third byte, or
// a byte marked final, closes a group; the group then produces four
// characters, the last of which carries final_char when the group ends the
// message. A byte can be taken every cycle while req_stall is low; the back
// end sends one character per cycle while rsp_stall is low, also from one
// group straight into the next, and every group gives four characters
// however many bytes it holds, so a full group of three bytes occupies the
// back end longer than its bytes take to arrive. The first character of a
// group passes through the group queue, the group register and the output register after the transfer of the byte
// that closes it. A two-entry group queue between the front and back ends absorbs
// short output stalls; req_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  b64se_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output b64se_pkg::rsp_payload_type rsp_payload
);
   import b64se_pkg::*;

   logic      push;
   group_type push_group;
   logic      queue_full;
   logic      pop;
   logic      queue_not_empty;
   group_type pop_group;

   // Byte collection and group closing.
   b64se_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_group  (push_group)
   );

   // Queue of closed groups.
   b64se_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .pop_group  (pop_group)
   );

   // Character generation and output stage.
   b64se_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_group     (pop_group),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

// File: rtl/b64se_front.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder front end
// Accepts message bytes, collects them into groups of three and pushes each
// closed group, zero-filled, into the group queue.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_unit_defines.svh"

module b64se_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  b64se_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push,
   output b64se_pkg::group_type      push_group
);
   import b64se_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] cnt;
   logic       accept;
   logic       closes;

   // Hold off new bytes while the queue has no room for a closed group.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // A count of three is never reached; it would behave as two.
   assign cnt    = (held_count_ff == 2'd3) ? 2'd2 : held_count_ff;
   assign closes = (cnt == 2'd2) || req_payload.final_byte;
   assign push   = accept && closes;

   // Assemble the group from the held bytes, the new byte and zero fill.
   always_comb begin
      push_group.byte0      = (cnt == 2'd0) ? req_payload.data_byte : held0_ff;
      push_group.byte1      = (cnt == 2'd0) ? 8'h00 :
                              ((cnt == 2'd1) ? req_payload.data_byte : held1_ff);
      push_group.byte2      = (cnt == 2'd2) ? req_payload.data_byte : 8'h00;
      push_group.held_count = cnt;
      push_group.last       = req_payload.final_byte;
   end

   // Store a pending byte, or clear the holding state once a group closes.
   always_comb begin
      held_count_in = held_count_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      if (accept) begin
         if (closes) begin
            held_count_in = 2'd0;
            held0_in      = 8'h00;
            held1_in      = 8'h00;
         end else begin
            held_count_in = cnt + 2'd1;
            if (cnt == 2'd0) begin
               held0_in = req_payload.data_byte;
            end else begin
               held1_in = req_payload.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         held0_ff      <= 8'h00;
         held1_ff      <= 8'h00;
      end else begin
         held_count_ff <= held_count_in;
         held0_ff      <= held0_in;
         held1_ff      <= held1_in;
      end
   end

   `B64SE_NEVER(a_front_count_range, held_count_ff == 2'd3, "front: held count reached three")

endmodule

// File: rtl/b64se_fifo.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder group queue
// A short first-in first-out queue of closed groups between the front end
// and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_unit_defines.svh"

module b64se_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64se_pkg::group_type push_group,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output b64se_pkg::group_type pop_group
);
   import b64se_pkg::*;

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   group_type             entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full      = (count_ff == CntWidth'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_group = entries_ff[rd_ptr_ff];

   // Advance the pointers with wrap-around at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Group storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   `B64SE_NEVER(a_fifo_overflow, push && full && !pop, "fifo: push into a full queue")
   `B64SE_NEVER(a_fifo_underflow, pop && !not_empty, "fifo: pop from an empty queue")
   `B64SE_ASSERT(a_fifo_count, push && !pop |=> count_ff == $past(count_ff) + 1'b1, "fifo: count did not rise on push")

endmodule

// File: rtl/b64se_back.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder back end
// Takes closed groups from the queue and sends out their four characters,
// one per transfer, through a registered output stage.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_unit_defines.svh"

module b64se_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_not_empty,
   input  b64se_pkg::group_type       queue_group,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output b64se_pkg::rsp_payload_type rsp_payload
);
   import b64se_pkg::*;

   group_type       cur_ff, cur_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [1:0]      pos_ff, pos_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            out_free;
   logic            advance;
   logic            group_done;
   logic [5:0]      idx;
   logic [2:0]      alpha_count;

   // The output stage can take a character when empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = cur_valid_ff && out_free;
   assign group_done = advance && (pos_ff == 2'd3);
   assign pop        = queue_not_empty && (!cur_valid_ff || group_done);

   // Pick the 6-bit index for the current character position.
   always_comb begin
      case (pos_ff)
         2'd0:    idx = cur_ff.byte0[7:2];
         2'd1:    idx = {cur_ff.byte0[1:0], cur_ff.byte1[7:4]};
         2'd2:    idx = {cur_ff.byte1[3:0], cur_ff.byte2[7:6]};
         default: idx = cur_ff.byte2[5:0];
      endcase
   end

   // A group of n bytes gives n+1 alphabet characters, then padding.
   assign alpha_count = {1'b0, cur_ff.held_count} + 3'd2;

   always_comb begin
      rsp_payload_in.char_code  = ({1'b0, pos_ff} < alpha_count) ? b64_char(idx) : PadChar;
      rsp_payload_in.final_char = cur_ff.last && (pos_ff == 2'd3);
   end

   // Group register and character position.
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (pop) begin
         cur_in       = queue_group;
         cur_valid_in = 1'b1;
         pos_in       = 2'd0;
      end else if (advance) begin
         pos_in = pos_ff + 2'd1;
         if (group_done) begin
            cur_valid_in = 1'b0;
         end
      end
   end

   // Output stage valid: load on advance, drop once the transfer is taken.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `B64SE_ASSERT(a_back_final_pos, advance && (pos_ff != 2'd3) |=> !rsp_payload_ff.final_char, "back: final mark before the fourth character")

endmodule

// File: test/base64_stream_encoder_unit_test.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder unit testbench
// Sends byte messages of mixed length through the encoder and checks every
// output character against a behavioral prediction of the Base64 grouping,
// zero fill and '=' padding. A short table of directed messages comes first.
// Some rows carry hand-written results. Random messages follow, with random
// gaps on both sides, one long receiver hold and pauses that drain the unit.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit_test;
   import b64se_pkg::*;

   localparam int unsigned RandomBytes = 450;
   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned HoldCycles  = 80;
   localparam int unsigned DrainCycles = 16;
   localparam logic [8*64-1:0] Alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                           "abcdefghijklmnopqrstuvwxyz",
                                           "0123456789+/"};
   localparam logic [7:0] PadCode = "=";

   // One row of the directed table. When typed is set, chars holds the four
   // characters of the group that the row closes, first character in the top
   // byte. The final mark on the fourth character follows final_byte.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        final_byte;
      logic        typed;
      logic [31:0] chars;
   } directed_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   // Hand-written result that goes with the byte now on offer.
   logic        offer_typed;
   logic [31:0] offer_chars;

   // Encoder state that the prediction keeps, and the characters it expects.
   logic [7:0]      pending_bytes [0:1];
   logic [1:0]      pending_count;
   rsp_payload_type expected_chars [$];

   directed_row_type directed_rows [$];

   int unsigned hold_requests = 0;
   logic        gaps_on;
   int unsigned no_gap_bytes;
   int unsigned idle_cycles;
   int unsigned bytes_taken = 0;
   int unsigned messages_taken = 0;
   int unsigned chars_checked = 0;
   int unsigned long_holds = 0;
   int unsigned errors = 0;
   int unsigned queued_before;
   logic        made_progress;
   rsp_payload_type oldest;

   base64_stream_encoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock with a period of 12.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Take one byte into the predicted encoder state. A byte that closes a
   // group queues four characters: count+2 alphabet codes, then '=' fill.
   function automatic void encode_byte(input logic [7:0] data, input logic fin);
      logic [7:0]      b0;
      logic [7:0]      b1;
      logic [7:0]      b2;
      logic [23:0]     group_bits;
      logic [5:0]      idx;
      rsp_payload_type ch;
      int              k;
      if (pending_count < 2'd2 && !fin) begin
         pending_bytes[pending_count[0]] = data;
         pending_count = pending_count + 2'd1;
         return;
      end
      b0 = (pending_count == 2'd0) ? data : pending_bytes[0];
      b1 = (pending_count == 2'd0) ? 8'h00 :
           (pending_count == 2'd1) ? data : pending_bytes[1];
      b2 = (pending_count == 2'd2) ? data : 8'h00;
      group_bits = {b0, b1, b2};
      for (k = 0; k < 4; k++) begin
         idx = group_bits[18 - 6 * k +: 6];
         ch.char_code = (k < int'(pending_count) + 2) ? Alphabet[8 * (63 - int'(idx)) +: 8]
                                                    : PadCode;
         ch.final_char = (k == 3) && fin;
         expected_chars.insert(expected_chars.size(), ch);
      end
      pending_bytes[0] = 8'h00;
      pending_bytes[1] = 8'h00;
      pending_count = 2'd0;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input logic [7:0] data, input logic fin,
                                   input logic typed, input logic [31:0] chars);
      directed_row_type row;
      row.data_byte = data;
      row.final_byte = fin;
      row.typed = typed;
      row.chars = chars;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Sender gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!gaps_on || no_gap_bytes > 0) begin
         return 0;
      end else if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(15, 40);
   endfunction

   // Offer one byte, hold it until the transfer, and return at a falling edge.
   task automatic offer_byte(input logic [7:0] data, input logic fin, input logic typed,
                             input logic [31:0] chars);
      int unsigned gap;
      gap = pick_gap();
      if (no_gap_bytes > 0) begin
         no_gap_bytes--;
      end
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.data_byte = data;
      req_payload.final_byte = fin;
      offer_typed = typed;
      offer_chars = chars;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait at a falling edge until every character is in.
   task automatic drain_unit();
      req_valid = 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver stall pattern: short stalls, rare long ones, calm stretches,
   // and a long hold when the sender asks for one.
   initial begin : receiver
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned r;
      stall_left = 0;
      calm_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != long_holds) begin
            stall_left = HoldCycles;
            calm_left = 0;
            long_holds++;
         end
         r = $urandom_range(0, 99);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (calm_left > 0) begin
            rsp_stall = 1'b0;
            calm_left--;
         end else if (r < 2) begin
            rsp_stall = 1'b0;
            calm_left = $urandom_range(40, 160);
         end else if (r < 72) begin
            rsp_stall = 1'b0;
         end else if (r < 96) begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Predict on each input transfer, check each output transfer, and watch
   // for a stretch of cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset) begin
         pending_bytes[0] = 8'h00;
         pending_bytes[1] = 8'h00;
         pending_count = 2'd0;
         idle_cycles = 0;
      end else begin
         made_progress = 1'b0;
         if (req_valid && !req_stall) begin
            made_progress = 1'b1;
            bytes_taken++;
            if (req_payload.final_byte) begin
               messages_taken++;
            end
            queued_before = expected_chars.size();
            encode_byte(req_payload.data_byte, req_payload.final_byte);
            if (offer_typed && expected_chars.size() == queued_before + 4) begin
               for (int k = 0; k < 4; k++) begin
                  expected_chars[queued_before + k].char_code = offer_chars[8 * (3 - k) +: 8];
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            made_progress = 1'b1;
            chars_checked++;
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected character, expected none, got %h final %b",
                        $time, rsp_payload.char_code, rsp_payload.final_char);
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_payload.char_code !== oldest.char_code) begin
                  errors++;
                  $display("%0t: char_code mismatch, expected %h got %h",
                           $time, oldest.char_code, rsp_payload.char_code);
               end
               if (rsp_payload.final_char !== oldest.final_char) begin
                  errors++;
                  $display("%0t: final_char mismatch, expected %b got %b",
                           $time, oldest.final_char, rsp_payload.final_char);
               end
            end
         end
         idle_cycles = made_progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, random messages, final drain.
   initial begin
      int unsigned random_sent;
      int unsigned msg_len;
      int unsigned r;
      int unsigned i;
      logic        hold_done;
      logic        pause_done;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      offer_typed = 1'b0;
      offer_chars = '0;
      gaps_on = 1'b1;
      no_gap_bytes = 0;
      random_sent = 0;
      hold_done = 1'b0;
      pause_done = 1'b0;

      // Single-byte messages at both extremes.
      add_row(8'h00, 1'b1, 1'b1, "AA==");
      add_row(8'hFF, 1'b1, 1'b1, "/w==");
      // A full group that does not end the message.
      add_row(8'h00, 1'b0, 1'b0, 32'h0);
      add_row(8'h00, 1'b0, 1'b0, 32'h0);
      add_row(8'h00, 1'b0, 1'b1, "AAAA");
      // A full group that ends the message.
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b1, 1'b1, "////");
      // Two-byte closing groups at both extremes.
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b1, 1'b1, "//8=");
      add_row(8'h00, 1'b0, 1'b0, 32'h0);
      add_row(8'h00, 1'b1, 1'b1, "AAA=");
      // Plain text, full and partial.
      add_row(8'h4D, 1'b0, 1'b0, 32'h0);
      add_row(8'h61, 1'b0, 1'b0, 32'h0);
      add_row(8'h6E, 1'b1, 1'b1, "TWFu");
      add_row(8'h4D, 1'b0, 1'b0, 32'h0);
      add_row(8'h61, 1'b1, 1'b1, "TWE=");
      // Mixed bit patterns, then a single-byte tail after a full group.
      add_row(8'hA5, 1'b0, 1'b0, 32'h0);
      add_row(8'h5A, 1'b0, 1'b0, 32'h0);
      add_row(8'h3C, 1'b0, 1'b0, 32'h0);
      add_row(8'hC3, 1'b1, 1'b0, 32'h0);
      // The alphabet code '+', outside letters and digits, in every position.
      add_row(8'hFB, 1'b0, 1'b0, 32'h0);
      add_row(8'hEF, 1'b0, 1'b0, 32'h0);
      add_row(8'hBE, 1'b1, 1'b0, 32'h0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n]) begin
         offer_byte(directed_rows[n].data_byte, directed_rows[n].final_byte,
                    directed_rows[n].typed, directed_rows[n].chars);
      end
      drain_unit();

      // Random messages: mostly short, some medium, a few long.
      while (random_sent < RandomBytes) begin
         r = $urandom_range(0, 99);
         msg_len = (r < 70) ? $urandom_range(1, 6) :
                   (r < 95) ? $urandom_range(7, 15) : $urandom_range(16, 40);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (!hold_done && random_sent >= 120) begin
            // Hold the receiver off while the sender keeps offering bytes.
            hold_done = 1'b1;
            hold_requests++;
            no_gap_bytes = 40;
         end
         if (!pause_done && random_sent >= 300) begin
            // Let the unit empty completely before going on.
            pause_done = 1'b1;
            drain_unit();
         end
         for (i = 0; i < msg_len; i++) begin
            offer_byte(8'($urandom_range(0, 255)), i == msg_len - 1, 1'b0, 32'h0);
         end
         random_sent += msg_len;
      end

      drain_unit();
      repeat (DrainCycles) @(posedge clock);
      $display("tb: %0d bytes in %0d messages encoded, %0d characters checked",
               bytes_taken, messages_taken, chars_checked);
      $display("tb: %0d long receiver holds, %0d mismatches", long_holds, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
